### hdl/cbc_pkg.sv
package cbc_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] REG_KIND    = 2'd0;
  localparam logic [1:0] REG_ROM_CNT = 2'd1;
  localparam logic [1:0] REG_RAM_CNT = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_MBC1 = 2'd1;
  localparam logic [1:0] KIND_MBC3 = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_XLATE = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RAM_OFF = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  localparam logic [1:0] SPACE_NONE = 2'd0;
  localparam logic [1:0] SPACE_ROM  = 2'd1;
  localparam logic [1:0] SPACE_RAM  = 2'd2;

  localparam logic [1:0] SEL_RAM_EN   = 2'd0;
  localparam logic [1:0] SEL_ROM_BANK = 2'd1;
  localparam logic [1:0] SEL_UPPER    = 2'd2;
  localparam logic [1:0] SEL_MODE     = 2'd3;

  localparam logic [7:0] RAM_EN_KEY  = 8'h0A;
  localparam logic [3:0] RAM_EN_NIB  = 4'hA;
  localparam logic [7:0] MBC3_RAM_BANKS = 8'd8;

  localparam logic [7:0] ROM_CNT_RESET = 8'd2;
  localparam logic [3:0] RAM_CNT_RESET = 4'd1;
  localparam logic [6:0] LOW_BANK_RESET = 7'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rom_cnt;
    logic [3:0] ram_cnt;
  } cfg_t;

  typedef struct packed {
    logic [6:0] low_rom_bank;
    logic [2:0] upper_bank;
    logic       ram_en;
    logic       adv_mode;
  } bank_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] cpu_addr;
    logic [7:0]  wr_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  target_space;
    logic [20:0] byte_offset;
  } rsp_t;

endpackage

### hdl/cbc_if.sv
interface cbc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] cpu_addr;
  logic [7:0]  wr_data;

  modport source (output valid, output req_type, output cpu_addr, output wr_data,
                  input ready);
  modport sink (input valid, input req_type, input cpu_addr, input wr_data,
                output ready);
endinterface

interface cbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  target_space;
  logic [20:0] byte_offset;

  modport source (output valid, output status, output target_space,
                  output byte_offset, input ready);
  modport sink (input valid, input status, input target_space,
                input byte_offset, output ready);
endinterface

### hdl/cbc_cfg.sv
module cbc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cbc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cbc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output cbc_pkg::cfg_t                    cfg_o
);

  cbc_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        cbc_pkg::REG_KIND:    cfg_d.kind    = pwdata[1:0];
        cbc_pkg::REG_ROM_CNT: cfg_d.rom_cnt = pwdata[7:0];
        cbc_pkg::REG_RAM_CNT: cfg_d.ram_cnt = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind    <= cbc_pkg::KIND_NONE;
      cfg_q.rom_cnt <= cbc_pkg::ROM_CNT_RESET;
      cfg_q.ram_cnt <= cbc_pkg::RAM_CNT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      cbc_pkg::REG_KIND:    prdata = {30'd0, cfg_q.kind};
      cbc_pkg::REG_ROM_CNT: prdata = {24'd0, cfg_q.rom_cnt};
      cbc_pkg::REG_RAM_CNT: prdata = {28'd0, cfg_q.ram_cnt};
      default:              prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/cbc_bank.sv
module cbc_bank (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cbc_pkg::cfg_t cfg_i,
  input  logic          upd_i,
  input  cbc_pkg::req_t req_i,
  output cbc_pkg::bank_t bank_o
);

  cbc_pkg::bank_t bank_q, bank_d;
  logic [1:0]     sel;

  function automatic logic [6:0] wrap_rom(input logic [6:0] b, input logic [7:0] cnt);
    logic [6:0] v;
    logic [7:0] mask;
    mask = cnt - 8'd1;
    v = (b == 7'd0) ? 7'd1 : b;
    if ({1'b0, v} >= cnt) begin
      v = v & mask[6:0];
    end
    return v;
  endfunction

  assign sel = req_i.cpu_addr[14:13];

  always_comb begin
    bank_d = bank_q;
    if (upd_i && req_i.req_type == cbc_pkg::REQ_WRITE && !req_i.cpu_addr[15]) begin
      if (cfg_i.kind == cbc_pkg::KIND_MBC1) begin
        unique case (sel)
          cbc_pkg::SEL_RAM_EN:   bank_d.ram_en = (req_i.wr_data[3:0] == cbc_pkg::RAM_EN_NIB);
          cbc_pkg::SEL_ROM_BANK: bank_d.low_rom_bank =
                                   wrap_rom({2'b00, req_i.wr_data[4:0]}, cfg_i.rom_cnt);
          cbc_pkg::SEL_UPPER:    bank_d.upper_bank = {1'b0, req_i.wr_data[1:0]};
          cbc_pkg::SEL_MODE:     bank_d.adv_mode = req_i.wr_data[0];
          default: ;
        endcase
      end else if (cfg_i.kind == cbc_pkg::KIND_MBC3) begin
        unique case (sel)
          cbc_pkg::SEL_RAM_EN:   bank_d.ram_en = (req_i.wr_data == cbc_pkg::RAM_EN_KEY);
          cbc_pkg::SEL_ROM_BANK: bank_d.low_rom_bank =
                                   wrap_rom(req_i.wr_data[6:0], cfg_i.rom_cnt);
          cbc_pkg::SEL_UPPER: begin
            if (req_i.wr_data < cbc_pkg::MBC3_RAM_BANKS) begin
              bank_d.upper_bank = req_i.wr_data[2:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q.low_rom_bank <= cbc_pkg::LOW_BANK_RESET;
      bank_q.upper_bank   <= 3'd0;
      bank_q.ram_en       <= 1'b0;
      bank_q.adv_mode     <= 1'b0;
    end else begin
      bank_q <= bank_d;
    end
  end

  assign bank_o = bank_q;

endmodule

### hdl/cbc_xlate.sv
module cbc_xlate (
  input  cbc_pkg::cfg_t  cfg_i,
  input  cbc_pkg::bank_t bank_i,
  input  cbc_pkg::req_t  req_i,
  output cbc_pkg::rsp_t  rsp_o
);

  always_comb begin
    logic [7:0]  rom_mask;
    logic [3:0]  ram_mask;
    logic [6:0]  rom_page;
    logic [2:0]  ram_page;
    logic [15:0] a;
    logic        is_mbc1;
    logic        is_mbc3;
    rom_mask = cfg_i.rom_cnt - 8'd1;
    ram_mask = cfg_i.ram_cnt - 4'd1;
    a        = req_i.cpu_addr;
    is_mbc1  = (cfg_i.kind == cbc_pkg::KIND_MBC1);
    is_mbc3  = (cfg_i.kind == cbc_pkg::KIND_MBC3);
    rom_page = 7'd0;
    ram_page = 3'd0;
    rsp_o.status       = cbc_pkg::STAT_OK;
    rsp_o.target_space = cbc_pkg::SPACE_NONE;
    rsp_o.byte_offset  = '0;
    if (req_i.req_type == cbc_pkg::REQ_WRITE) begin
      if (a[15]) begin
        rsp_o.status = cbc_pkg::STAT_INVALID;
      end
    end else if (a[15:14] == 2'b00) begin
      if (is_mbc1 && bank_i.adv_mode) begin
        rom_page = {bank_i.upper_bank[1:0], 5'd0} & rom_mask[6:0];
      end
      rsp_o.target_space = cbc_pkg::SPACE_ROM;
      rsp_o.byte_offset  = {rom_page, a[13:0]};
    end else if (a[15:14] == 2'b01) begin
      if (is_mbc1) begin
        rom_page = (bank_i.low_rom_bank | {bank_i.upper_bank[1:0], 5'd0}) & rom_mask[6:0];
      end else if (is_mbc3) begin
        rom_page = bank_i.low_rom_bank;
      end else begin
        rom_page = 7'd1;
      end
      rsp_o.target_space = cbc_pkg::SPACE_ROM;
      rsp_o.byte_offset  = {rom_page, a[13:0]};
    end else if (a[15:13] == 3'b101) begin
      if ((is_mbc1 || is_mbc3) && !bank_i.ram_en) begin
        rsp_o.status = cbc_pkg::STAT_RAM_OFF;
      end else begin
        if (is_mbc1) begin
          if (bank_i.adv_mode) begin
            ram_page = {1'b0, bank_i.upper_bank[1:0] & ram_mask[1:0]};
          end
        end else if (is_mbc3) begin
          ram_page = bank_i.upper_bank;
        end
        rsp_o.target_space = cbc_pkg::SPACE_RAM;
        rsp_o.byte_offset  = {5'd0, ram_page, a[12:0]};
      end
    end else begin
      rsp_o.status = cbc_pkg::STAT_INVALID;
    end
  end

endmodule

### hdl/cartridge_bank_controller_unit.sv
// Cartridge bank controller with no-controller, MBC1 and MBC3 modes.
// Request channel (req_i): one item per CPU bus access, either a bank
// register write or an address translation. Response channel (rsp_o): one
// item per request, in order, with status, target space and byte offset.
// An APB port sets controller kind, ROM bank count and RAM bank count;
// write it only while no request is in flight.
// Flow: a request is registered in the input register, evaluated there
// against the bank registers and loaded into the response register, from
// which rsp_o takes it.
// Throughput: one item per cycle unless rsp_o stalls; a translation sees a
// bank register write accepted in the cycle before it, since bank registers
// update as the write item moves into the response register.
// Stall: the input register and the response register each hold one item,
// so one more request is taken while a response waits; ready drops only
// when both are full and rsp_o.ready is low.
// Reset: configuration returns to no controller, 2 ROM banks, 1 RAM bank;
// ROM bank 1, upper bank 0, RAM disabled, simple mode; both stages empty.
module cartridge_bank_controller_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cbc_req_if.sink                        req_i,
  cbc_rsp_if.source                      rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cbc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  cbc_pkg::cfg_t  cfg;
  cbc_pkg::bank_t bank;
  cbc_pkg::req_t  s1_req_q, s1_req_d;
  cbc_pkg::rsp_t  s2_rsp_q, s2_rsp_d;
  logic           s1_valid_q, s1_valid_d;
  logic           s2_valid_q, s2_valid_d;
  logic           s2_load;
  logic           s1_adv;
  logic           in_ready;

  cbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s2_load  = !s2_valid_q || rsp_o.ready;
  assign s1_adv   = s1_valid_q && s2_load;
  assign in_ready = !s1_valid_q || s2_load;
  assign req_i.ready = in_ready;

  cbc_bank u_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .upd_i  (s1_adv),
    .req_i  (s1_req_q),
    .bank_o (bank)
  );

  cbc_xlate u_xlate (
    .cfg_i  (cfg),
    .bank_i (bank),
    .req_i  (s1_req_q),
    .rsp_o  (s2_rsp_d)
  );

  assign s1_valid_d = in_ready ? req_i.valid : s1_valid_q;
  assign s2_valid_d = s2_load ? s1_valid_q : s2_valid_q;
  assign s1_req_d   = '{req_type: req_i.req_type, cpu_addr: req_i.cpu_addr,
                        wr_data: req_i.wr_data};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      s1_req_q <= s1_req_d;
    end
    if (s1_adv) begin
      s2_rsp_q <= s2_rsp_d;
    end
  end

  assign rsp_o.valid        = s2_valid_q;
  assign rsp_o.status       = s2_rsp_q.status;
  assign rsp_o.target_space = s2_rsp_q.target_space;
  assign rsp_o.byte_offset  = s2_rsp_q.byte_offset;

  a_adv_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> rsp_o.valid)
    else $error("advanced item did not reach the response register");

  a_high_write_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_req_q.req_type == cbc_pkg::REQ_WRITE && s1_req_q.cpu_addr[15])
    |=> (rsp_o.status == cbc_pkg::STAT_INVALID))
    else $error("write at or above 0x8000 not flagged invalid");

  a_high_write_keeps_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_req_q.req_type == cbc_pkg::REQ_WRITE && s1_req_q.cpu_addr[15])
    |=> $stable(bank))
    else $error("write at or above 0x8000 changed bank state");

  a_none_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.target_space == cbc_pkg::SPACE_NONE) |-> (rsp_o.byte_offset == '0))
    else $error("nonzero offset with no target space");

  a_err_no_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != cbc_pkg::STAT_OK)
    |-> (rsp_o.target_space == cbc_pkg::SPACE_NONE))
    else $error("flagged item carries a target space");

endmodule
